FILE: rtl/isetm_pkg.sv
`timescale 1ns / 1ps
package isetm_pkg;

  localparam int MAX_RANGES = 64;
  localparam int IDX_W      = $clog2(MAX_RANGES);
  localparam int CNT_W      = 7;
  localparam int PID_W      = 22;
  localparam int ADDR_W     = 48;
  localparam int LIM_W      = ADDR_W + 1;

  typedef enum logic [1:0] {
    OP_LOOKUP = 2'd0,
    OP_INSERT = 2'd1,
    OP_CLEAR  = 2'd2,
    OP_NONE   = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    STATUS_OK   = 2'd0,
    STATUS_FULL = 2'd1,
    STATUS_BAD  = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_DRAIN,
    S_COMMIT
  } fsm_t;

  typedef struct packed {
    logic [PID_W-1:0]  owner;
    logic [ADDR_W-1:0] base;
    logic [LIM_W-1:0]  limit;
  } entry_t;

endpackage

FILE: rtl/interval_set_merge_table.sv
`timescale 1ns / 1ps
// Interval table of 64 entries, each an interval [base, limit) owned by a
// process id; inserts merge every overlapping or touching interval of the same
// process into the lowest absorbed slot. A lookup or an accepted insert scans
// every entry before its result beat: the table sits in a single-read-port
// memory and one compare unit visits one entry per cycle, followed by a drain
// state to finish the last compare and a commit state to write the merged
// entry. A clear, a rejected insert and the unused op give their beat in the
// cycle after acceptance and keep busy low. Valid bits are flops, so no
// clearing pass follows reset. Each result beat is shown for one cycle with
// done high; the receiver cannot stall it, so capture it then.
module interval_set_merge_table (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  output logic                        busy,
  input  logic [1:0]                  op,
  input  logic [isetm_pkg::PID_W-1:0] proc_id,
  input  logic [isetm_pkg::ADDR_W-1:0] address,
  input  logic [isetm_pkg::ADDR_W-1:0] length,
  output logic                        done,
  output logic                        hit,
  output logic [1:0]                  status,
  output logic [isetm_pkg::CNT_W-1:0] used_count
);
  import isetm_pkg::*;

  fsm_t state, state_next;

  logic [MAX_RANGES-1:0] valid, valid_next;
  logic [MAX_RANGES-1:0] absorb;
  logic [CNT_W-1:0]      used, used_next;
  logic [CNT_W-1:0]      absorb_cnt;
  logic [IDX_W-1:0]      idx, pidx, tgt, free_slot, slot;
  logic                  pv, have_target, have_free, hit_acc;
  logic                  res_done, res_hit;
  logic [1:0]            res_status;
  logic [CNT_W-1:0]      res_count;

  op_t               op_q, op_in;
  logic [PID_W-1:0]  pid_q;
  logic [ADDR_W-1:0] lo, ns;
  logic [LIM_W-1:0]  hi, ne, hi_in;

  logic   accept, bad_in, scan_in, last, ins_ok;
  logic   own, ovl, hit_now, free_now;
  logic   mem_we;
  entry_t rd, mem_wdata;

  isetm_mem u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (slot),
    .wdata (mem_wdata),
    .raddr (idx),
    .rdata (rd)
  );

  assign op_in  = op_t'(op);
  assign accept = start && !busy;
  assign hi_in  = {1'b0, address} + {1'b0, length};
  assign bad_in = (length == '0) || (hi_in[ADDR_W] && (hi_in[ADDR_W-1:0] != '0));
  assign scan_in = (op_in == OP_LOOKUP) || ((op_in == OP_INSERT) && !bad_in);
  assign last   = (idx == IDX_W'(MAX_RANGES - 1));

  // compare unit: one entry per cycle
  assign own      = pv && valid[pidx] && (rd.owner == pid_q);
  assign ovl      = own && ({1'b0, rd.base} <= hi) && (rd.limit >= {1'b0, lo});
  assign hit_now  = own && (rd.base <= lo) && ({1'b0, lo} < rd.limit);
  assign free_now = pv && !valid[pidx] && !have_free;

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE:   if (accept && scan_in) state_next = S_SCAN;
      S_SCAN:   if (last) state_next = S_DRAIN;
      S_DRAIN:  state_next = S_COMMIT;
      S_COMMIT: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    busy      = (state != S_IDLE);
    ins_ok    = (op_q == OP_INSERT) && (have_target || have_free);
    slot      = have_target ? tgt : free_slot;
    mem_we    = (state == S_COMMIT) && ins_ok;
    mem_wdata = '{owner: pid_q, base: ns, limit: ne};
    if (have_target) begin
      valid_next = (valid & ~absorb) | (MAX_RANGES'(1) << tgt);
      used_next  = used - absorb_cnt + CNT_W'(1);
    end else begin
      valid_next = valid | (MAX_RANGES'(1) << free_slot);
      used_next  = used + CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      valid       <= '0;
      used        <= '0;
      res_done    <= 1'b0;
      pv          <= 1'b0;
      idx         <= '0;
      have_target <= 1'b0;
      have_free   <= 1'b0;
      hit_acc     <= 1'b0;
      absorb      <= '0;
    end else begin
      state    <= state_next;
      res_done <= (accept && !scan_in) || (state == S_COMMIT);
      pv       <= (state == S_SCAN);
      if (state == S_SCAN) begin
        idx <= idx + IDX_W'(1);
      end
      if (ovl) begin
        have_target  <= 1'b1;
        absorb[pidx] <= 1'b1;
      end
      if (free_now) begin
        have_free <= 1'b1;
      end
      if (hit_now) begin
        hit_acc <= 1'b1;
      end
      if (accept) begin
        idx         <= '0;
        have_target <= 1'b0;
        have_free   <= 1'b0;
        hit_acc     <= 1'b0;
        absorb      <= '0;
        if (op_in == OP_CLEAR) begin
          valid <= '0;
          used  <= '0;
        end
      end
      if (state == S_COMMIT) begin
        if (ins_ok) begin
          valid <= valid_next;
          used  <= used_next;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    pidx <= idx;
    if (ovl) begin
      if (rd.base < ns) ns <= rd.base;
      if (rd.limit > ne) ne <= rd.limit;
      if (!have_target) tgt <= pidx;
      absorb_cnt <= absorb_cnt + CNT_W'(1);
    end
    if (free_now) begin
      free_slot <= pidx;
    end
    if (accept) begin
      op_q       <= op_in;
      pid_q      <= proc_id;
      lo         <= address;
      hi         <= hi_in;
      ns         <= address;
      ne         <= hi_in;
      absorb_cnt <= '0;
      res_hit    <= 1'b0;
      res_count  <= (op_in == OP_CLEAR) ? '0 : used;
      res_status <= (op_in == OP_INSERT && bad_in) ? STATUS_BAD : STATUS_OK;
    end
    if (state == S_COMMIT) begin
      res_hit <= (op_q == OP_LOOKUP) && hit_acc;
      if (ins_ok) begin
        res_count  <= used_next;
        res_status <= STATUS_OK;
      end else begin
        res_count  <= used;
        res_status <= (op_q == OP_INSERT) ? STATUS_FULL : STATUS_OK;
      end
    end
  end

  assign done       = res_done;
  assign hit        = res_hit;
  assign status     = res_status;
  assign used_count = res_count;

endmodule

FILE: rtl/isetm_mem.sv
`timescale 1ns / 1ps
module isetm_mem (
  input  logic                  clk,
  input  logic                  we,
  input  logic [isetm_pkg::IDX_W-1:0] waddr,
  input  isetm_pkg::entry_t     wdata,
  input  logic [isetm_pkg::IDX_W-1:0] raddr,
  output isetm_pkg::entry_t     rdata
);
  import isetm_pkg::*;

  entry_t mem [MAX_RANGES];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: bench/testbench.sv
`timescale 1ns / 1ps
module testbench;
  import isetm_pkg::*;

  localparam logic [ADDR_W-1:0] ADDR_MAX = '1;
  localparam logic [LIM_W-1:0]  ADDR_TOP = {1'b1, {ADDR_W{1'b0}}};

  typedef struct {
    logic             hit;
    status_t          status;
    logic [CNT_W-1:0] used;
  } reply_t;

  class interval_tracker;
    bit                slot_valid [MAX_RANGES];
    logic [PID_W-1:0]  slot_owner [MAX_RANGES];
    logic [ADDR_W-1:0] slot_base  [MAX_RANGES];
    logic [LIM_W-1:0]  slot_limit [MAX_RANGES];
    reply_t            pending_replies [$];
    int                fail_count;

    function new();
      foreach (slot_valid[i]) slot_valid[i] = 1'b0;
      fail_count = 0;
    endfunction

    function void predict_request(op_t code, logic [PID_W-1:0] pid,
                                  logic [ADDR_W-1:0] addr, logic [ADDR_W-1:0] len);
      reply_t           r;
      logic [LIM_W-1:0] lo, hi, new_lo, new_hi;
      bit               absorb [MAX_RANGES];
      int               target, free_slot;
      r.hit    = 1'b0;
      r.status = STATUS_OK;
      case (code)
        OP_LOOKUP: begin
          foreach (slot_valid[i])
            if (slot_valid[i] && slot_owner[i] == pid && slot_base[i] <= addr &&
                {1'b0, addr} < slot_limit[i])
              r.hit = 1'b1;
        end
        OP_INSERT: begin
          lo = {1'b0, addr};
          hi = lo + {1'b0, len};
          if (len == '0 || hi > ADDR_TOP) begin
            r.status = STATUS_BAD;
          end else begin
            new_lo    = lo;
            new_hi    = hi;
            target    = -1;
            free_slot = -1;
            for (int i = 0; i < MAX_RANGES; i++) begin
              absorb[i] = slot_valid[i] && slot_owner[i] == pid &&
                          {1'b0, slot_base[i]} <= hi && slot_limit[i] >= lo;
              if (absorb[i]) begin
                if ({1'b0, slot_base[i]} < new_lo) new_lo = {1'b0, slot_base[i]};
                if (slot_limit[i] > new_hi) new_hi = slot_limit[i];
                if (target < 0) target = i;
              end else if (!slot_valid[i] && free_slot < 0) begin
                free_slot = i;
              end
            end
            if (target < 0 && free_slot < 0) begin
              r.status = STATUS_FULL;
            end else begin
              if (target < 0) target = free_slot;
              foreach (absorb[i]) if (absorb[i]) slot_valid[i] = 1'b0;
              slot_valid[target] = 1'b1;
              slot_owner[target] = pid;
              slot_base[target]  = new_lo[ADDR_W-1:0];
              slot_limit[target] = new_hi;
            end
          end
        end
        OP_CLEAR: begin
          foreach (slot_valid[i]) slot_valid[i] = 1'b0;
        end
        default: ;
      endcase
      r.used = '0;
      foreach (slot_valid[i]) r.used += CNT_W'(slot_valid[i]);
      pending_replies.push_back(r);
    endfunction

    function void check_reply(logic got_hit, logic [1:0] got_status,
                              logic [CNT_W-1:0] got_used);
      reply_t want;
      if (pending_replies.size() == 0) begin
        $error("reply beat with no request outstanding");
        fail_count++;
        return;
      end
      want = pending_replies.pop_front();
      if (got_hit !== want.hit) begin
        $error("hit: expected %0d, got %0d", want.hit, got_hit);
        fail_count++;
      end
      if (got_status !== want.status) begin
        $error("status: expected %0d, got %0d", want.status, got_status);
        fail_count++;
      end
      if (got_used !== want.used) begin
        $error("used_count: expected %0d, got %0d", want.used, got_used);
        fail_count++;
      end
    endfunction
  endclass

  logic                clk        = 1'b0;
  logic                rst        = 1'b1;
  logic                start      = 1'b0;
  logic [1:0]          op         = '0;
  logic [PID_W-1:0]    proc_id    = '0;
  logic [ADDR_W-1:0]   address    = '0;
  logic [ADDR_W-1:0]   length     = '0;
  logic                busy;
  logic                done;
  logic                hit;
  logic [1:0]          status;
  logic [CNT_W-1:0]    used_count;

  interval_tracker     tracker;
  int                  idle_pct = 0;
  logic [PID_W-1:0]    pid_pool [4];
  logic [ADDR_W-1:0]   region;
  logic [PID_W-1:0]    last_pid;
  logic [ADDR_W-1:0]   last_addr;

  always #5 clk = ~clk;

  interval_set_merge_table u_top (
    .clk        (clk),
    .rst        (rst),
    .start      (start),
    .busy       (busy),
    .op         (op),
    .proc_id    (proc_id),
    .address    (address),
    .length     (length),
    .done       (done),
    .hit        (hit),
    .status     (status),
    .used_count (used_count)
  );

  always @(posedge clk) begin
    if (!rst && done) tracker.check_reply(hit, status, used_count);
  end

  task automatic send_request(input op_t code, input logic [PID_W-1:0] pid,
                              input logic [ADDR_W-1:0] addr, input logic [ADDR_W-1:0] len);
    int gap;
    gap = 0;
    if ($urandom_range(0, 99) < idle_pct) gap = $urandom_range(1, 4);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start   <= 1'b1;
    op      <= code;
    proc_id <= pid;
    address <= addr;
    length  <= len;
    do @(posedge clk); while (busy);
    tracker.predict_request(code, pid, addr, len);
  endtask

  task automatic pick_working_set();
    foreach (pid_pool[i]) pid_pool[i] = PID_W'($urandom);
    region    = ADDR_W'({$urandom, $urandom}) & 48'h7FFF_FFFF_F000;
    last_pid  = pid_pool[0];
    last_addr = region;
  endtask

  task automatic random_request();
    int                kind;
    op_t               code;
    logic [PID_W-1:0]  pid;
    logic [ADDR_W-1:0] addr, len;
    kind = $urandom_range(0, 999);
    pid  = pid_pool[$urandom_range(0, 3)];
    addr = region + ADDR_W'($urandom_range(0, 4095));
    len  = ADDR_W'($urandom_range(1, 24));
    if (kind < 440) begin
      code = OP_LOOKUP;
      if ($urandom_range(0, 1) == 1) begin
        pid  = last_pid;
        addr = last_addr + ADDR_W'($urandom_range(0, 30));
      end
    end else if (kind < 900) begin
      code      = OP_INSERT;
      last_pid  = pid;
      last_addr = addr;
    end else if (kind < 903) begin
      code = OP_CLEAR;
    end else if (kind < 920) begin
      code = OP_NONE;
    end else if (kind < 950) begin
      // crowd the top of the address space
      code = ($urandom_range(0, 1) == 1) ? OP_INSERT : OP_LOOKUP;
      addr = ADDR_MAX - ADDR_W'($urandom_range(0, 63));
      len  = ADDR_W'($urandom_range(0, 80));
    end else begin
      code = ($urandom_range(0, 1) == 1) ? OP_INSERT : OP_LOOKUP;
      pid  = PID_W'($urandom);
      addr = ADDR_W'({$urandom, $urandom});
      len  = ($urandom_range(0, 1) == 1) ? ADDR_W'({$urandom, $urandom})
                                         : ADDR_W'($urandom_range(0, 3));
    end
    if (code == OP_INSERT && $urandom_range(0, 49) == 0) len = '0;
    send_request(code, pid, addr, len);
    if (code == OP_CLEAR) pick_working_set();
  endtask

  initial begin
    int idle_plan [4];
    int waited;
    idle_plan = '{0, 58, 0, 26};
    tracker = new();
    pick_working_set();
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    send_request(OP_LOOKUP, 22'd5, 48'd100, 48'd0);
    send_request(OP_INSERT, 22'd5, 48'd100, 48'd0);
    send_request(OP_INSERT, 22'd5, 48'd100, 48'd100);
    send_request(OP_INSERT, 22'd5, 48'd200, 48'd100);
    send_request(OP_LOOKUP, 22'd5, 48'd299, 48'd0);
    send_request(OP_LOOKUP, 22'd5, 48'd300, 48'd0);
    send_request(OP_LOOKUP, 22'd5, 48'd99, 48'd0);
    send_request(OP_INSERT, 22'd7, 48'd150, 48'd10);
    send_request(OP_INSERT, 22'd5, 48'd400, 48'd100);
    send_request(OP_INSERT, 22'd5, 48'd600, 48'd100);
    send_request(OP_INSERT, 22'd5, 48'd250, 48'd400);
    send_request(OP_LOOKUP, 22'd5, 48'd550, 48'd0);
    send_request(OP_LOOKUP, 22'd7, 48'd550, 48'd0);
    send_request(OP_INSERT, '1, ADDR_MAX, 48'd1);
    send_request(OP_LOOKUP, '1, ADDR_MAX, ADDR_MAX);
    send_request(OP_INSERT, '1, ADDR_MAX, 48'd2);
    send_request(OP_INSERT, 22'd0, 48'd0, ADDR_MAX);
    send_request(OP_LOOKUP, 22'd0, ADDR_MAX, 48'd0);
    send_request(OP_INSERT, 22'd0, ADDR_MAX, ADDR_MAX);
    send_request(OP_INSERT, 22'd0, 48'd1, ADDR_MAX);
    send_request(OP_LOOKUP, 22'd0, ADDR_MAX, 48'd0);
    send_request(OP_NONE, '1, ADDR_MAX, ADDR_MAX);
    send_request(OP_CLEAR, '1, ADDR_MAX, ADDR_MAX);
    send_request(OP_LOOKUP, 22'd5, 48'd550, 48'd0);

    foreach (idle_plan[ph]) begin
      idle_pct = idle_plan[ph];
      repeat (457) random_request();
    end
    start <= 1'b0;

    waited = 0;
    while (tracker.pending_replies.size() != 0 && waited < 200) begin
      @(posedge clk);
      waited++;
    end
    repeat (80) @(posedge clk);
    if (tracker.pending_replies.size() != 0) begin
      $error("%0d replies never arrived", tracker.pending_replies.size());
      tracker.fail_count++;
    end
    if (tracker.fail_count == 0) begin
      $display("testbench: PASS");
    end else begin
      $display("testbench: FAIL");
    end
    $finish;
  end

  initial begin
    #20_000_000;
    $display("testbench: FAIL");
    $finish;
  end

endmodule

FILE: filelist.f
rtl/isetm_pkg.sv
rtl/isetm_mem.sv
rtl/interval_set_merge_table.sv
bench/testbench.sv
